FILE: hdl/mp2_pkg.sv
package mp2_pkg;

  localparam int MAX_DIM   = 256;
  localparam int MAX_WORDS = 128;
  localparam int LANES     = 4;

  localparam int LANE_W = 8;
  localparam int DATA_W = LANES * LANE_W;
  localparam int DIM_W  = $clog2(MAX_DIM);     // row / column counters
  localparam int HW     = DIM_W + 1;           // height and width registers
  localparam int WORD_W = $clog2(MAX_WORDS);   // channel word counter
  localparam int CWW    = WORD_W + 1;          // channel_words register
  localparam int LS_AW  = DIM_W + WORD_W;      // line store address

  localparam int NRES      = 4;                // results per input at most
  localparam int RES_IDX_W = $clog2(NRES);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = HW;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEIGHT      = 3'd0,
    REG_WIDTH       = 3'd1,
    REG_CHAN_WORDS  = 3'd2,
    REG_STRIDE_TWO  = 3'd3,
    REG_PAD_RIGHT   = 3'd4,
    REG_PAD_BOTTOM  = 3'd5
  } cfg_reg_t;

  // Clamped and derived configuration seen by the datapath
  typedef struct packed {
    logic             s2;
    logic             pr;
    logic             pb;
    logic [DIM_W-1:0] h_last;
    logic [DIM_W-1:0] wd_last;
    logic [WORD_W-1:0] cw_last;
    logic [DIM_W-1:0] oh_last;
    logic [DIM_W-1:0] ow_last;
  } cfg_t;

  // One input word together with its neighborhood, as read from the stores
  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] cur;
    logic [DATA_W-1:0] left;
    logic [DATA_W-1:0] up;
    logic [DATA_W-1:0] upleft;
    logic [DIM_W-1:0]  r;
    logic [DIM_W-1:0]  c;
    logic [WORD_W-1:0] w;
  } item_t;

  function automatic logic [DATA_W-1:0] lane_max(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] res;
    res = '0;
    for (int k = 0; k < LANES; k++) begin
      if ($signed(a[k*LANE_W +: LANE_W]) >= $signed(b[k*LANE_W +: LANE_W])) begin
        res[k*LANE_W +: LANE_W] = a[k*LANE_W +: LANE_W];
      end else begin
        res[k*LANE_W +: LANE_W] = b[k*LANE_W +: LANE_W];
      end
    end
    return res;
  endfunction

endpackage

FILE: hdl/mp2_if.sv
interface mp2_in_if;
  logic                       valid;
  logic                       ready;
  logic [mp2_pkg::DATA_W-1:0] pixel_word;

  modport source (output valid, output pixel_word, input ready);
  modport sink   (input valid, input pixel_word, output ready);
endinterface

interface mp2_out_if;
  logic                       valid;
  logic                       ready;
  logic [mp2_pkg::DATA_W-1:0] pooled_word;
  logic [mp2_pkg::DIM_W-1:0]  out_row;
  logic [mp2_pkg::DIM_W-1:0]  out_col;
  logic [mp2_pkg::WORD_W-1:0] out_word;
  logic                       last_of_run;
  logic                       last_of_frame;

  modport source (output valid, output pooled_word, output out_row, output out_col,
                  output out_word, output last_of_run, output last_of_frame,
                  input ready);
  modport sink   (input valid, input pooled_word, input out_row, input out_col,
                  input out_word, input last_of_run, input last_of_frame,
                  output ready);
endinterface

FILE: hdl/mp2_cfg.sv
module mp2_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mp2_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mp2_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output mp2_pkg::cfg_t                  cfg,
  output logic                           restart
);
  import mp2_pkg::*;

  logic [HW-1:0]  height_r, width_r;
  logic [CWW-1:0] chan_words_r;
  logic           stride_two_r, pad_right_r, pad_bottom_r;

  logic [HW-1:0]  h_cl, wd_cl, oh, ow;
  logic [CWW-1:0] cw_cl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r     <= HW'(2);
      width_r      <= HW'(2);
      chan_words_r <= CWW'(1);
      stride_two_r <= 1'b1;
      pad_right_r  <= 1'b0;
      pad_bottom_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEIGHT:     height_r     <= cfg_wdata;
        REG_WIDTH:      width_r      <= cfg_wdata;
        REG_CHAN_WORDS: chan_words_r <= cfg_wdata[CWW-1:0];
        REG_STRIDE_TWO: stride_two_r <= cfg_wdata[0];
        REG_PAD_RIGHT:  pad_right_r  <= cfg_wdata[0];
        REG_PAD_BOTTOM: pad_bottom_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // any write to a defined register restarts the frame
  always_comb begin
    restart = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        REG_HEIGHT, REG_WIDTH, REG_CHAN_WORDS,
        REG_STRIDE_TWO, REG_PAD_RIGHT, REG_PAD_BOTTOM: restart = 1'b1;
        default: restart = 1'b0;
      endcase
    end
  end

  always_comb begin
    h_cl  = (height_r < HW'(2)) ? HW'(2) :
            (height_r > HW'(MAX_DIM)) ? HW'(MAX_DIM) : height_r;
    wd_cl = (width_r < HW'(2)) ? HW'(2) :
            (width_r > HW'(MAX_DIM)) ? HW'(MAX_DIM) : width_r;
    cw_cl = (chan_words_r < CWW'(1)) ? CWW'(1) :
            (chan_words_r > CWW'(MAX_WORDS)) ? CWW'(MAX_WORDS) : chan_words_r;

    cfg.s2 = stride_two_r;
    cfg.pr = !stride_two_r && pad_right_r;
    cfg.pb = !stride_two_r && pad_bottom_r;

    oh = stride_two_r ? (h_cl >> 1) : (h_cl - HW'(1) + HW'(cfg.pb));
    ow = stride_two_r ? (wd_cl >> 1) : (wd_cl - HW'(1) + HW'(cfg.pr));

    cfg.h_last  = DIM_W'(h_cl - HW'(1));
    cfg.wd_last = DIM_W'(wd_cl - HW'(1));
    cfg.cw_last = WORD_W'(cw_cl - CWW'(1));
    cfg.oh_last = DIM_W'(oh - HW'(1));
    cfg.ow_last = DIM_W'(ow - HW'(1));
  end

endmodule

FILE: hdl/mp2_fetch.sv
module mp2_fetch (
  input  logic          clk,
  input  logic          rst_n,
  input  mp2_pkg::cfg_t cfg,
  input  logic          restart,
  mp2_in_if.sink        in_ch,
  input  logic          adv,
  output mp2_pkg::item_t item
);
  import mp2_pkg::*;

  logic [DATA_W-1:0] line_mem [1 << LS_AW];
  logic [DATA_W-1:0] col_mem  [1 << WORD_W];
  logic [DATA_W-1:0] up_mem   [1 << WORD_W];

  logic [DIM_W-1:0]  r_r, c_r, r_nxt, c_nxt;
  logic [WORD_W-1:0] w_r, w_nxt;

  logic              s1_valid_r, s1_valid_nxt;
  logic [DATA_W-1:0] s1_cur_r, s1_left_r, s1_up_r, s1_upleft_r;
  logic [DIM_W-1:0]  s1_r_r, s1_c_r;
  logic [WORD_W-1:0] s1_w_r;

  logic acc, up_we;

  assign in_ch.ready = !s1_valid_r || adv;
  assign acc         = in_ch.valid && in_ch.ready;
  // the row above, one column back, is the up word of the previous column
  assign up_we       = s1_valid_r && adv;

  always_comb begin
    r_nxt = r_r;
    c_nxt = c_r;
    w_nxt = w_r + WORD_W'(1);
    if (w_r == cfg.cw_last) begin
      w_nxt = '0;
      c_nxt = c_r + DIM_W'(1);
      if (c_r == cfg.wd_last) begin
        c_nxt = '0;
        r_nxt = (r_r == cfg.h_last) ? '0 : r_r + DIM_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_r <= '0;
      c_r <= '0;
      w_r <= '0;
    end else if (restart) begin
      r_r <= '0;
      c_r <= '0;
      w_r <= '0;
    end else if (acc) begin
      r_r <= r_nxt;
      c_r <= c_nxt;
      w_r <= w_nxt;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (acc) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_cur_r <= in_ch.pixel_word;
      s1_r_r   <= r_r;
      s1_c_r   <= c_r;
      s1_w_r   <= w_r;
    end
  end

  // line store: read the row above, replace it with the current row
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_up_r            <= line_mem[{c_r, w_r}];
      line_mem[{c_r, w_r}] <= in_ch.pixel_word;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_left_r    <= col_mem[w_r];
      col_mem[w_r] <= in_ch.pixel_word;
    end
  end

  // bypass covers one channel word per pixel, where the write lands on the read edge
  always_ff @(posedge clk) begin
    if (up_we) begin
      up_mem[s1_w_r] <= s1_up_r;
    end
    if (acc) begin
      s1_upleft_r <= (up_we && s1_w_r == w_r) ? s1_up_r : up_mem[w_r];
    end
  end

  always_comb begin
    item.valid  = s1_valid_r;
    item.cur    = s1_cur_r;
    item.left   = s1_left_r;
    item.up     = s1_up_r;
    item.upleft = s1_upleft_r;
    item.r      = s1_r_r;
    item.c      = s1_c_r;
    item.w      = s1_w_r;
  end

endmodule

FILE: hdl/mp2_emit.sv
module mp2_emit (
  input  logic           clk,
  input  logic           rst_n,
  input  mp2_pkg::cfg_t  cfg,
  input  mp2_pkg::item_t item,
  output logic           adv,
  mp2_out_if.source      out_ch
);
  import mp2_pkg::*;

  typedef enum logic [RES_IDX_W-1:0] {
    RES_WIN    = 2'd0,
    RES_RIGHT  = 2'd1,
    RES_BOTTOM = 2'd2,
    RES_CORNER = 2'd3
  } res_kind_t;

  logic [NRES-1:0]   mask, pending, sel_oh, rem, sent_r, sent_nxt;
  logic [RES_IDX_W-1:0] sel_idx;
  logic [DATA_W-1:0] res_val [NRES];
  logic [DIM_W-1:0]  res_row [NRES];
  logic [DIM_W-1:0]  res_col [NRES];
  logic              load;
  logic              at_last_col, at_last_row;

  logic              ov_r;
  logic [DATA_W-1:0] pooled_r;
  logic [DIM_W-1:0]  row_r, col_r;
  logic [WORD_W-1:0] word_r;
  logic              lrun_r, lframe_r;

  always_comb begin
    at_last_col = (item.c == cfg.wd_last);
    at_last_row = (item.r == cfg.h_last);

    mask = '0;
    mask[RES_WIN]    = item.valid && item.r != '0 && item.c != '0 &&
                       (!cfg.s2 || (item.r[0] && item.c[0]));
    mask[RES_RIGHT]  = item.valid && cfg.pr && item.r != '0 && at_last_col;
    mask[RES_BOTTOM] = item.valid && cfg.pb && at_last_row && item.c != '0;
    mask[RES_CORNER] = item.valid && cfg.pr && cfg.pb && at_last_row && at_last_col;

    res_val[RES_WIN] = lane_max(lane_max(item.upleft, item.up),
                                lane_max(item.left, item.cur));
    res_row[RES_WIN] = cfg.s2 ? (item.r >> 1) : item.r - DIM_W'(1);
    res_col[RES_WIN] = cfg.s2 ? (item.c >> 1) : item.c - DIM_W'(1);

    res_val[RES_RIGHT] = lane_max(item.up, item.cur);
    res_row[RES_RIGHT] = item.r - DIM_W'(1);
    res_col[RES_RIGHT] = cfg.wd_last;

    res_val[RES_BOTTOM] = lane_max(item.left, item.cur);
    res_row[RES_BOTTOM] = cfg.h_last;
    res_col[RES_BOTTOM] = item.c - DIM_W'(1);

    res_val[RES_CORNER] = item.cur;
    res_row[RES_CORNER] = cfg.h_last;
    res_col[RES_CORNER] = cfg.wd_last;
  end

  // pick the first result not yet handed to the output register
  always_comb begin
    pending = mask & ~sent_r;
    sel_idx = '0;
    for (int i = NRES - 1; i >= 0; i--) begin
      if (pending[i]) begin
        sel_idx = RES_IDX_W'(i);
      end
    end
    sel_oh = NRES'(1) << sel_idx;
    rem    = pending & ~sel_oh;
    load   = (pending != '0) && (!ov_r || out_ch.ready);
    adv    = item.valid && ((pending == '0) || (load && rem == '0));

    sent_nxt = sent_r;
    if (adv) begin
      sent_nxt = '0;
    end else if (load) begin
      sent_nxt = sent_r | sel_oh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sent_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      sent_r <= sent_nxt;
      if (load) begin
        ov_r <= 1'b1;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pooled_r <= res_val[sel_idx];
      row_r    <= res_row[sel_idx];
      col_r    <= res_col[sel_idx];
      word_r   <= item.w;
      lrun_r   <= (rem == '0);
      lframe_r <= (res_row[sel_idx] == cfg.oh_last) && (res_col[sel_idx] == cfg.ow_last) &&
                  (item.w == cfg.cw_last);
    end
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.pooled_word   = pooled_r;
  assign out_ch.out_row       = row_r;
  assign out_ch.out_col       = col_r;
  assign out_ch.out_word      = word_r;
  assign out_ch.last_of_run   = lrun_r;
  assign out_ch.last_of_frame = lframe_r;

endmodule

FILE: hdl/int8_maxpool_2x2_stream.sv
// Streaming 2x2 max pooling over packed int8 feature maps (four signed lanes per
// 32-bit word, raster order row / column / channel word). While the output is not
// stalled, a word is taken every cycle as long as it causes at most one result; a
// word causing n results (n up to 4, only with stride-1 padding at the last column
// or row) holds the input while the output register gives one result per cycle when
// not stalled. Results pass the stage-1 registers and then the output register. The
// previous row lives in a 32768 x 32 single-port line store that is read and
// overwritten at the same address in the same cycle; two 128-word stores hold the
// previous column and the row above it. The stores are not cleared after reset, so
// no clearing pass is needed. A write to a defined configuration register restarts
// the frame at row 0, column 0, word 0; configure only while no transaction is in flight.
module int8_maxpool_2x2_stream (
  input  logic                           clk,
  input  logic                           rst_n,
  mp2_in_if.sink                         in_ch,
  mp2_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [mp2_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mp2_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import mp2_pkg::*;

  cfg_t  cfg;
  item_t item;
  logic  restart;
  logic  adv;

  mp2_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .restart   (restart)
  );

  mp2_fetch u_fetch (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .restart (restart),
    .in_ch   (in_ch),
    .adv     (adv),
    .item    (item)
  );

  mp2_emit u_emit (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .item   (item),
    .adv    (adv),
    .out_ch (out_ch)
  );

endmodule
